/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tbk_pkg.sv */
// ----------------------------------------------------------------------------
// tbk_pkg
// shared widths, codes and types of the thermistor to kelvin pipeline
// ----------------------------------------------------------------------------
package tbk_pkg;

    localparam int SUPPLY_W   = 13;
    localparam int REF_W      = 16;
    localparam int COEF_W     = 32;
    localparam int RT_W       = 24;
    localparam int RT_FRAC    = 8;
    localparam int P_W        = 5;
    localparam int X_W        = 31;
    localparam int LOG_FRAC   = 24;
    localparam int LGM_W      = 28;
    localparam int LN2_W      = 30;
    localparam int LM_W       = 28;
    localparam int L2_W       = 32;
    localparam int BT_W       = 36;
    localparam int L3_W       = 28;
    localparam int CT_W       = 44;
    localparam int SUM_W      = 45;
    localparam int INV_W      = 48;
    localparam int IV_W       = 47;
    localparam int T_W        = 10;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam logic [T_W-1:0]   TEMP_MAX = 10'd1023;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd4;

    localparam logic [SUPPLY_W-1:0] RST_SUPPLY = 13'd3300;
    localparam logic [REF_W-1:0]    RST_REF    = 16'd10000;
    localparam logic [COEF_W-1:0]   RST_COEF_A = 32'd1135714107;
    localparam logic [COEF_W-1:0]   RST_COEF_B = 32'd262147468;
    localparam logic [COEF_W-1:0]   RST_COEF_C = 32'd176087;

    typedef struct packed {
        logic valid;
        logic bad;
    } t_ctl;

endpackage

/* hdl/tbk_rt.sv */
// ----------------------------------------------------------------------------
// tbk_rt
// bridge resistance in Q16.8, one quotient bit per stage
// ----------------------------------------------------------------------------
module tbk_rt #(
    parameter int SENSE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [SENSE_BITS-1:0]         i_sense,
    input  logic [tbk_pkg::SUPPLY_W-1:0]  i_supply,
    input  logic [tbk_pkg::REF_W-1:0]     i_ref,
    output tbk_pkg::t_ctl                 o_ctl,
    output logic [tbk_pkg::RT_W-1:0]      o_rt
);
    import tbk_pkg::*;

    localparam int CW    = (SENSE_BITS + 1 > SUPPLY_W) ? SENSE_BITS + 1 : SUPPLY_W;
    localparam int RW    = CW + 2;
    localparam int NUM_W = REF_W + SUPPLY_W;

    logic [CW-1:0]    s_ext;
    logic [CW-1:0]    tv_ext;
    logic [CW-1:0]    diff;
    logic [CW:0]      den;
    logic [NUM_W-1:0] num;

    logic          r_valid [0:RT_W];
    logic          r_bad   [0:RT_W];
    logic [RW-1:0] r_rem   [0:RT_W];
    logic [RT_W-1:0] r_low [0:RT_W];
    logic [RT_W-1:0] r_q   [0:RT_W];
    logic [CW:0]   r_den   [0:RT_W];

    assign s_ext  = CW'(i_supply);
    assign tv_ext = CW'({i_sense, 1'b0});
    assign diff   = s_ext - tv_ext;
    assign den    = {1'b0, s_ext} + {1'b0, tv_ext};
    assign num    = NUM_W'(i_ref) * NUM_W'(diff[SUPPLY_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad[0] <= (s_ext <= tv_ext) || (i_ref == '0);
            r_rem[0] <= RW'(num[NUM_W-1:RT_W-RT_FRAC]);
            r_low[0] <= {num[RT_W-RT_FRAC-1:0], {RT_FRAC{1'b0}}};
            r_q[0]   <= '0;
            r_den[0] <= den;
        end
    end

    for (genvar i = 0; i < RT_W; i++) begin : g_div
        logic [RW-1:0] rem_sh;
        logic          ge;

        assign rem_sh = {r_rem[i][RW-2:0], r_low[i][RT_W-1]};
        assign ge     = rem_sh >= RW'(r_den[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bad[i+1] <= r_bad[i];
                r_rem[i+1] <= ge ? rem_sh - RW'(r_den[i]) : rem_sh;
                r_low[i+1] <= {r_low[i][RT_W-2:0], 1'b0};
                r_q[i+1]   <= {r_q[i][RT_W-2:0], ge};
                r_den[i+1] <= r_den[i];
            end
        end
    end

    assign o_ctl.valid = r_valid[RT_W];
    assign o_ctl.bad   = r_bad[RT_W];
    assign o_rt        = r_q[RT_W];

endmodule

/* hdl/tbk_log2.sv */
// ----------------------------------------------------------------------------
// tbk_log2
// normalize, then one squaring stage per fraction bit of log2
// ----------------------------------------------------------------------------
module tbk_log2 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tbk_pkg::t_ctl                i_ctl,
    input  logic [tbk_pkg::RT_W-1:0]     i_rt,
    output tbk_pkg::t_ctl                o_ctl,
    output logic                         o_neg,
    output logic [tbk_pkg::LGM_W-1:0]    o_mag
);
    import tbk_pkg::*;

    logic [P_W-1:0] n_p;
    logic [P_W-1:0] sh;

    logic             r_valid [0:LOG_FRAC];
    logic             r_bad   [0:LOG_FRAC];
    logic [P_W-1:0]   r_p     [0:LOG_FRAC];
    logic [X_W-1:0]   r_x     [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_f  [0:LOG_FRAC];

    logic             r_lg_valid;
    logic             r_lg_bad;
    logic             r_lg_neg;
    logic [LGM_W-1:0] r_lg_mag;

    always_comb begin
        n_p = '0;
        for (int k = 0; k < RT_W; k++) begin
            if (i_rt[k]) begin
                n_p = P_W'(k);
            end
        end
    end

    assign sh = P_W'(X_W - 1) - n_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad[0] <= i_ctl.bad || (i_rt == '0);
            r_p[0]   <= n_p;
            r_x[0]   <= X_W'(i_rt) << sh;
            r_f[0]   <= '0;
        end
    end

    for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
        logic [2*X_W-1:0] sq;
        logic [X_W:0]     y;

        assign sq = r_x[i] * r_x[i];
        assign y  = sq[2*X_W-1:X_W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bad[i+1] <= r_bad[i];
                r_p[i+1]   <= r_p[i];
                r_x[i+1]   <= y[X_W] ? y[X_W:1] : y[X_W-1:0];
                r_f[i+1]   <= {r_f[i][LOG_FRAC-2:0], y[X_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_valid <= 1'b0;
        end else if (i_en) begin
            r_lg_valid <= r_valid[LOG_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lg_bad <= r_bad[LOG_FRAC];
            r_lg_neg <= r_p[LOG_FRAC] < P_W'(RT_FRAC);
            if (r_p[LOG_FRAC] < P_W'(RT_FRAC)) begin
                r_lg_mag <= (LGM_W'(P_W'(RT_FRAC) - r_p[LOG_FRAC]) << LOG_FRAC)
                            - LGM_W'(r_f[LOG_FRAC]);
            end else begin
                r_lg_mag <= (LGM_W'(r_p[LOG_FRAC] - P_W'(RT_FRAC)) << LOG_FRAC)
                            + LGM_W'(r_f[LOG_FRAC]);
            end
        end
    end

    assign o_ctl.valid = r_lg_valid;
    assign o_ctl.bad   = r_lg_bad;
    assign o_neg       = r_lg_neg;
    assign o_mag       = r_lg_mag;

endmodule

/* hdl/tbk_poly.sv */
// ----------------------------------------------------------------------------
// tbk_poly
// natural log and the steinhart-hart polynomial, as a pipeline of multiplies and adds
// ----------------------------------------------------------------------------
module tbk_poly (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  tbk_pkg::t_ctl                 i_ctl,
    input  logic                          i_neg,
    input  logic [tbk_pkg::LGM_W-1:0]     i_mag,
    input  logic [tbk_pkg::COEF_W-1:0]    i_coef_a,
    input  logic [tbk_pkg::COEF_W-1:0]    i_coef_b,
    input  logic [tbk_pkg::COEF_W-1:0]    i_coef_c,
    output tbk_pkg::t_ctl                 o_ctl,
    output logic [tbk_pkg::IV_W-1:0]      o_inv
);
    import tbk_pkg::*;

    localparam int NS = 6;

    logic [LGM_W+LN2_W-1:0]  p_ln;
    logic [2*LM_W-1:0]       p_l2;
    logic [COEF_W+LM_W-1:0]  p_bt;
    logic [L2_W+LM_W-1:0]    p_l3;
    logic [COEF_W+L3_W-1:0]  p_ct;
    logic [INV_W-1:0]        a_ext;
    logic [INV_W-1:0]        n_inv;

    logic           r_valid [0:NS-1];
    logic           r_bad   [0:NS-1];
    logic           r_neg   [0:NS-2];
    logic [LM_W-1:0] r_lm1, r_lm2;
    logic [L2_W-1:0] r_l2;
    logic [BT_W-1:0] r_bt2, r_bt3, r_bt4;
    logic [L3_W-1:0] r_l3;
    logic [CT_W-1:0] r_ct4;
    logic [SUM_W-1:0] r_sum;
    logic [IV_W-1:0] r_inv;

    assign p_ln  = (LGM_W+LN2_W)'(i_mag) * (LGM_W+LN2_W)'(LN2_Q30);
    assign p_l2  = (2*LM_W)'(r_lm1) * (2*LM_W)'(r_lm1);
    assign p_bt  = (COEF_W+LM_W)'(i_coef_b) * (COEF_W+LM_W)'(r_lm1);
    assign p_l3  = (L2_W+LM_W)'(r_l2) * (L2_W+LM_W)'(r_lm2);
    assign p_ct  = (COEF_W+L3_W)'(i_coef_c) * (COEF_W+L3_W)'(r_l3);
    assign a_ext = INV_W'(i_coef_a);
    assign n_inv = r_neg[NS-2] ? a_ext - INV_W'(r_sum) : a_ext + INV_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_ctl.valid;
            for (int k = 1; k < NS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad[0] <= i_ctl.bad;
            r_neg[0] <= i_neg;
            for (int k = 1; k < NS - 1; k++) begin
                r_bad[k] <= r_bad[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            r_lm1 <= p_ln[LGM_W+LN2_W-1:LN2_W];
            r_lm2 <= r_lm1;
            r_l2  <= p_l2[2*LM_W-1:LOG_FRAC];
            r_bt2 <= p_bt[COEF_W+LM_W-1:LOG_FRAC];
            r_l3  <= p_l3[L2_W+LM_W-1:L2_W];
            r_bt3 <= r_bt2;
            r_ct4 <= p_ct[COEF_W+L3_W-1:COEF_W+L3_W-CT_W];
            r_bt4 <= r_bt3;
            r_sum <= SUM_W'(r_bt4) + SUM_W'(r_ct4);
            r_bad[NS-1] <= r_bad[NS-2] || n_inv[INV_W-1] || (n_inv == '0);
            r_inv <= n_inv[IV_W-1:0];
        end
    end

    assign o_ctl.valid = r_valid[NS-1];
    assign o_ctl.bad   = r_bad[NS-1];
    assign o_inv       = r_inv;

endmodule

/* hdl/tbk_recip.sv */
// ----------------------------------------------------------------------------
// tbk_recip
// kelvin from the inverse, one quotient bit per stage, then status
// ----------------------------------------------------------------------------
module tbk_recip #(
    parameter int COEF_FRAC_BITS = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  tbk_pkg::t_ctl               i_ctl,
    input  logic [tbk_pkg::IV_W-1:0]    i_inv,
    output logic                        o_valid,
    output logic [tbk_pkg::T_W-1:0]     o_temp,
    output logic [tbk_pkg::ST_W-1:0]    o_status
);
    import tbk_pkg::*;

    localparam int DW = IV_W + T_W;

    logic           r_valid [0:T_W];
    logic           r_bad   [0:T_W];
    logic           r_sat   [0:T_W];
    logic [DW-1:0]  r_rem   [0:T_W];
    logic [IV_W-1:0] r_inv  [0:T_W];
    logic [T_W-1:0] r_q     [0:T_W];

    logic            r_out_valid;
    logic [T_W-1:0]  r_temp;
    logic [ST_W-1:0] r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad[0] <= i_ctl.bad;
            r_sat[0] <= DW'(i_inv) <= (DW'(1) << (COEF_FRAC_BITS - T_W));
            r_rem[0] <= DW'(1) << COEF_FRAC_BITS;
            r_inv[0] <= i_inv;
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < T_W; j++) begin : g_div
        logic [DW-1:0] d;
        logic          ge;

        assign d  = DW'(r_inv[j]) << (T_W - 1 - j);
        assign ge = r_rem[j] >= d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bad[j+1] <= r_bad[j];
                r_sat[j+1] <= r_sat[j];
                r_rem[j+1] <= ge ? r_rem[j] - d : r_rem[j];
                r_inv[j+1] <= r_inv[j];
                r_q[j+1]   <= {r_q[j][T_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[T_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_bad[T_W]) begin
                r_temp   <= '0;
                r_status <= ST_BAD;
            end else if (r_sat[T_W]) begin
                r_temp   <= TEMP_MAX;
                r_status <= ST_SAT;
            end else begin
                r_temp   <= r_q[T_W];
                r_status <= ST_OK;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_temp   = r_temp;
    assign o_status = r_status;

endmodule

/* hdl/thermistor_bridge_to_kelvin.sv */
// ----------------------------------------------------------------------------
// thermistor_bridge_to_kelvin
// bridge voltage in millivolts to thermistor temperature in kelvin
// ----------------------------------------------------------------------------
// A word enters every cycle unless stalled and passes through 1 input
// stage, 24 resistance divide stages, 1 normalize, 24 log2 squaring stages,
// 1 log stage, 6 polynomial stages, 1 saturation check, 10 reciprocal divide
// stages and the output register. The whole pipeline advances together and
// holds while the output word waits for i_ready. Configuration writes are
// taken every cycle; supply and reference are read as a word enters and the
// coefficients in the polynomial stages, so write them only while the
// pipeline is empty.
module thermistor_bridge_to_kelvin #(
    parameter int SENSE_BITS     = 12,
    parameter int COEF_FRAC_BITS = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tbk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbk_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [SENSE_BITS-1:0]            i_sense_millivolts,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [tbk_pkg::T_W-1:0]          o_temperature_kelvin,
    output logic [tbk_pkg::ST_W-1:0]         o_status
);
    import tbk_pkg::*;

    logic [SUPPLY_W-1:0] r_supply;
    logic [REF_W-1:0]    r_ref;
    logic [COEF_W-1:0]   r_coef_a;
    logic [COEF_W-1:0]   r_coef_b;
    logic [COEF_W-1:0]   r_coef_c;

    logic             en;
    t_ctl             rt_ctl;
    logic [RT_W-1:0]  rt;
    t_ctl             lg_ctl;
    logic             lg_neg;
    logic [LGM_W-1:0] lg_mag;
    t_ctl             pl_ctl;
    logic [IV_W-1:0]  pl_inv;

    assign o_cfg_ready = 1'b1;
    assign en          = !o_valid || i_ready;
    assign o_ready     = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= RST_SUPPLY;
            r_ref    <= RST_REF;
            r_coef_a <= RST_COEF_A;
            r_coef_b <= RST_COEF_B;
            r_coef_c <= RST_COEF_C;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SUPPLY: begin
                    r_supply <= i_cfg_data[SUPPLY_W-1:0];
                end
                REG_REF: begin
                    r_ref <= i_cfg_data[REF_W-1:0];
                end
                REG_COEF_A: begin
                    r_coef_a <= i_cfg_data[COEF_W-1:0];
                end
                REG_COEF_B: begin
                    r_coef_b <= i_cfg_data[COEF_W-1:0];
                end
                REG_COEF_C: begin
                    r_coef_c <= i_cfg_data[COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tbk_rt #(
        .SENSE_BITS (SENSE_BITS)
    ) u_rt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_sense  (i_sense_millivolts),
        .i_supply (r_supply),
        .i_ref    (r_ref),
        .o_ctl    (rt_ctl),
        .o_rt     (rt)
    );

    tbk_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (rt_ctl),
        .i_rt    (rt),
        .o_ctl   (lg_ctl),
        .o_neg   (lg_neg),
        .o_mag   (lg_mag)
    );

    tbk_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (lg_ctl),
        .i_neg    (lg_neg),
        .i_mag    (lg_mag),
        .i_coef_a (r_coef_a),
        .i_coef_b (r_coef_b),
        .i_coef_c (r_coef_c),
        .o_ctl    (pl_ctl),
        .o_inv    (pl_inv)
    );

    tbk_recip #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (pl_ctl),
        .i_inv    (pl_inv),
        .o_valid  (o_valid),
        .o_temp   (o_temperature_kelvin),
        .o_status (o_status)
    );

endmodule

/* hdl/tbk_checker.sv */
// ----------------------------------------------------------------------------
// tbk_checker
// port-level checks of the thermistor to kelvin block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbk_checker #(
    parameter int SENSE_BITS = 12
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [tbk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [tbk_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [SENSE_BITS-1:0]            i_sense_millivolts,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [tbk_pkg::T_W-1:0]          o_temperature_kelvin,
    input logic [tbk_pkg::ST_W-1:0]         o_status
);
    import tbk_pkg::*;

    `ASSERT_NEXT_RST(a_rst_empty, !i_rst_n, !o_valid, "output word after reset")
    `ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_temperature_kelvin) && $stable(o_status), "stalled word changed")
    `ASSERT_IMPL(a_code, o_valid, o_status == ST_OK || o_status == ST_BAD || o_status == ST_SAT, "unknown status")
    `ASSERT_IMPL(a_bad_zero, o_valid && o_status == ST_BAD, o_temperature_kelvin == '0, "invalid word not zero")
    `ASSERT_IMPL(a_sat_max, o_valid && o_status == ST_SAT, o_temperature_kelvin == TEMP_MAX, "saturated word not max")

endmodule

bind thermistor_bridge_to_kelvin tbk_checker #(.SENSE_BITS(SENSE_BITS)) u_tbk_checker (.*);
